/* rtl/owtr_pkg.sv */
`default_nettype none

package owtr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_WR_LOW    = 4'd4,
        PH_WR_DATA   = 4'd5,
        PH_CONVERT   = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_SAMPLE = 4'd8,
        PH_RD_REST   = 4'd9
    } t_phase;

    localparam int WAIT_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT  = 3'd6;

    // command sequence positions
    localparam logic [2:0] CMD_SKIP_1   = 3'd0;
    localparam logic [2:0] CMD_CONVERT  = 3'd1;
    localparam logic [2:0] CMD_SKIP_2   = 3'd2;
    localparam logic [2:0] CMD_READ_SP  = 3'd3;
    localparam logic [2:0] CMD_RD_LSB   = 3'd4;
    localparam logic [2:0] CMD_RD_MSB   = 3'd5;

    localparam logic [7:0] OP_SKIP_ROM = 8'hCC;
    localparam logic [7:0] OP_CONVERT  = 8'h44;
    localparam logic [7:0] OP_READ_SP  = 8'hBE;

    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [7:0]  presence_wait_us;
        logic [9:0]  reset_recover_us;
        logic [3:0]  write_low_us;
        logic [3:0]  read_low_us;
        logic [6:0]  slot_us;
        logic [19:0] convert_wait_us;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [WAIT_W-1:0]   wait_count;
        logic [2:0]          bit_index;
        logic [2:0]          command_index;
        logic [7:0]          shift_byte;
        logic [7:0]          low_byte;
        logic                presence_flag;
        logic signed [15:0]  temperature_value;
    } t_state;

    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = OP_SKIP_ROM;
            2'd1:    b = OP_CONVERT;
            2'd2:    b = OP_SKIP_ROM;
            default: b = OP_READ_SP;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/owtr_step.sv */
`default_nettype none

module owtr_step
    import owtr_pkg::*;
(
    input  wire t_state i_state,
    input  wire t_cfg   i_cfg,
    input  wire         i_start_req,
    input  wire         i_tick_us,
    input  wire         i_line_level,
    output t_state      o_state,
    output logic        o_pull_low,
    output logic        o_done
);

    logic [WAIT_W-1:0] target;
    logic              timer_hit;
    logic [WAIT_W-1:0] wc_timed;
    logic [7:0]        cur_byte;

    always_comb begin
        case (i_state.phase)
            PH_RST_LOW:  target = WAIT_W'(i_cfg.reset_low_us);
            PH_RST_WAIT: target = WAIT_W'(i_cfg.presence_wait_us);
            PH_RST_REC:  target = WAIT_W'(i_cfg.reset_recover_us);
            PH_WR_LOW:   target = WAIT_W'(i_cfg.write_low_us);
            PH_WR_DATA:  target = WAIT_W'(i_cfg.slot_us);
            PH_CONVERT:  target = i_cfg.convert_wait_us;
            PH_RD_LOW:   target = WAIT_W'(i_cfg.read_low_us);
            PH_RD_REST:  target = WAIT_W'(i_cfg.slot_us);
            default:     target = '0;
        endcase
    end

    assign timer_hit = (i_state.wait_count >= target);
    assign wc_timed  = timer_hit ? '0 :
                       (i_tick_us ? i_state.wait_count + WAIT_W'(1) : i_state.wait_count);

    always_comb begin
        o_state = i_state;
        o_done  = 1'b0;
        case (i_state.phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    o_state.phase         = PH_RST_LOW;
                    o_state.wait_count    = '0;
                    o_state.command_index = CMD_SKIP_1;
                    o_state.bit_index     = '0;
                end
            end
            PH_RST_LOW: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) o_state.phase = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) begin
                    o_state.presence_flag = ~i_line_level;
                    o_state.phase         = PH_RST_REC;
                end
            end
            PH_RST_REC: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) begin
                    o_state.bit_index = '0;
                    o_state.phase     = PH_WR_LOW;
                end
            end
            PH_WR_LOW: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) o_state.phase = PH_WR_DATA;
            end
            PH_WR_DATA: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) begin
                    if (i_state.bit_index != 3'd7) begin
                        o_state.bit_index = i_state.bit_index + 3'd1;
                        o_state.phase     = PH_WR_LOW;
                    end else begin
                        o_state.bit_index = '0;
                        if (i_state.command_index == CMD_SKIP_1 ||
                            i_state.command_index == CMD_SKIP_2) begin
                            o_state.command_index = i_state.command_index + 3'd1;
                            o_state.phase         = PH_WR_LOW;
                        end else if (i_state.command_index == CMD_CONVERT) begin
                            o_state.command_index = CMD_SKIP_2;
                            o_state.phase         = PH_CONVERT;
                        end else begin
                            o_state.command_index = CMD_RD_LSB;
                            o_state.shift_byte    = '0;
                            o_state.phase         = PH_RD_LOW;
                        end
                    end
                end
            end
            PH_CONVERT: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) o_state.phase = PH_RST_LOW;
            end
            PH_RD_LOW: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) o_state.phase = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                o_state.shift_byte = {i_line_level, i_state.shift_byte[7:1]};
                o_state.wait_count = '0;
                o_state.phase      = PH_RD_REST;
            end
            PH_RD_REST: begin
                o_state.wait_count = wc_timed;
                if (timer_hit) begin
                    if (i_state.bit_index != 3'd7) begin
                        o_state.bit_index = i_state.bit_index + 3'd1;
                        o_state.phase     = PH_RD_LOW;
                    end else begin
                        o_state.bit_index = '0;
                        if (i_state.command_index == CMD_RD_LSB) begin
                            o_state.low_byte      = i_state.shift_byte;
                            o_state.shift_byte    = '0;
                            o_state.command_index = CMD_RD_MSB;
                            o_state.phase         = PH_RD_LOW;
                        end else begin
                            o_state.temperature_value =
                                {i_state.shift_byte, i_state.low_byte};
                            o_state.command_index = CMD_SKIP_1;
                            o_state.phase         = PH_IDLE;
                            o_done                = 1'b1;
                        end
                    end
                end
            end
            default: begin
                o_state.phase         = PH_IDLE;
                o_state.wait_count    = '0;
                o_state.bit_index     = '0;
                o_state.command_index = CMD_SKIP_1;
            end
        endcase
    end

    // a one bit is sent by releasing the line for the data part of the slot
    assign cur_byte = cmd_byte(o_state.command_index[1:0]);

    always_comb begin
        case (o_state.phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: o_pull_low = 1'b1;
            PH_WR_DATA: o_pull_low = ~cur_byte[o_state.bit_index];
            default:    o_pull_low = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/one_wire_temperature_reader.sv */
// Latency: a result appears on the master side in the cycle after its input transfer.
// Throughput: one input transfer per cycle; the bus controller advances one step per
// transfer, and the output register accepts while empty or while its result is taken.
// Reset: synchronous, active low; controller idle, its counters and results zero,
// timing registers back to their default microsecond values; payload not reset.
`default_nettype none

module one_wire_temperature_reader
    import owtr_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [7:0]            s_axis_tdata,  // [0] start_req, [1] tick_us, [2] line_level
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // [0] pull_low, [1] busy_res, [2] done_res,
                                                 // [3] presence, [19:4] temperature
    input  wire                   i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   n_pull;
    logic   n_done;
    logic   accept;

    logic               r_out_valid;
    logic               r_pull;
    logic               r_busy;
    logic               r_done;
    logic               r_presence;
    logic signed [15:0] r_temperature;

    owtr_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_start_req  (s_axis_tdata[0]),
        .i_tick_us    (s_axis_tdata[1]),
        .i_line_level (s_axis_tdata[2]),
        .o_state      (n_state),
        .o_pull_low   (n_pull),
        .o_done       (n_done)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us     <= 10'd480;
            r_cfg.presence_wait_us <= 8'd80;
            r_cfg.reset_recover_us <= 10'd400;
            r_cfg.write_low_us     <= 4'd1;
            r_cfg.read_low_us      <= 4'd2;
            r_cfg.slot_us          <= 7'd60;
            r_cfg.convert_wait_us  <= 20'd750000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RESET_LOW:     r_cfg.reset_low_us     <= i_cfg_data[9:0];
                CFG_PRESENCE_WAIT: r_cfg.presence_wait_us <= i_cfg_data[7:0];
                CFG_RESET_RECOVER: r_cfg.reset_recover_us <= i_cfg_data[9:0];
                CFG_WRITE_LOW:     r_cfg.write_low_us     <= i_cfg_data[3:0];
                CFG_READ_LOW:      r_cfg.read_low_us      <= i_cfg_data[3:0];
                CFG_SLOT:          r_cfg.slot_us          <= i_cfg_data[6:0];
                CFG_CONVERT_WAIT:  r_cfg.convert_wait_us  <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase             <= PH_IDLE;
            r_state.wait_count        <= '0;
            r_state.bit_index         <= '0;
            r_state.command_index     <= CMD_SKIP_1;
            r_state.shift_byte        <= '0;
            r_state.low_byte          <= '0;
            r_state.presence_flag     <= 1'b0;
            r_state.temperature_value <= '0;
            r_out_valid               <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on every input transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pull        <= n_pull;
            r_busy        <= (n_state.phase != PH_IDLE);
            r_done        <= n_done;
            r_presence    <= n_state.presence_flag;
            r_temperature <= n_state.temperature_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_temperature, r_presence, r_done, r_busy, r_pull};

endmodule

`default_nettype wire
